FILE: src/bitmap_id_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the ID allocator RTL
// Immediate-implication and next-cycle-implication checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIDA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bida_pkg
// Types, command codes and helpers for the bitmap ID allocator.
// ----------------------------------------------------------------------------
package bida_pkg;

    localparam int ID_W      = 10;
    localparam int CNT_OUT_W = 11;
    localparam int CMD_W     = 3;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BIT_W-1:0]  bit_pos_t;
    typedef logic [CMD_W-1:0]  cmd_t;

    localparam cmd_t CMD_ALLOC   = 3'd0;
    localparam cmd_t CMD_CLAIM   = 3'd1;
    localparam cmd_t CMD_RELEASE = 3'd2;
    localparam cmd_t CMD_QUERY   = 3'd3;
    localparam cmd_t CMD_CLEAR   = 3'd4;

    // Index of the lowest set bit; zero when the word is empty.
    function automatic bit_pos_t lowest_one(input word_t w);
        bit_pos_t pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: src/bida_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bida_map_ram
// Used-bitmap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bida_map_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  bida_pkg::word_t     wdata,
    input  logic [AW-1:0]       raddr,
    output bida_pkg::word_t     rdata
);

    bida_pkg::word_t mem [DEPTH];
    bida_pkg::word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bida_word_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bida_word_scan
// Masks one bitmap word to the live part of the search and finds the
// lowest free bit in it.
// ----------------------------------------------------------------------------
module bida_word_scan #(
    parameter int AW = 5
) (
    input  bida_pkg::word_t     data,
    input  logic [AW-1:0]       word,
    input  logic                wrapped,
    input  logic [AW-1:0]       start_word,
    input  bida_pkg::bit_pos_t  start_bit,
    input  logic [AW-1:0]       last_word,
    input  bida_pkg::bit_pos_t  last_bit,
    output logic                found,
    output bida_pkg::bit_pos_t  pos
);

    bida_pkg::word_t upper_mask;
    bida_pkg::word_t start_mask;
    bida_pkg::word_t end_mask;
    bida_pkg::word_t free_bits;

    always_comb
    begin
        upper_mask = {bida_pkg::WORD_W{1'b1}} << start_bit;
        // First pass covers bits at or above the start; the wrap pass the rest.
        if (word == start_word)
        begin
            start_mask = wrapped ? ~upper_mask : upper_mask;
        end
        else
        begin
            start_mask = '1;
        end
        // Drop bits past the end of the ID range.
        if (word == last_word)
        begin
            end_mask = {bida_pkg::WORD_W{1'b1}} >> (5'd31 - last_bit);
        end
        else
        begin
            end_mask = '1;
        end
        free_bits = ~data & start_mask & end_mask;
    end

    assign found = |free_bits;
    assign pos   = bida_pkg::lowest_one(free_bits);

endmodule

FILE: src/bitmap_id_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator_core
// Next-fit ID allocator over a used-bitmap held in a synchronous RAM.
//
// Hands out IDs from first_id up to MAX_IDS-1, one request transaction at a
// time, each answered by exactly one response transaction carrying the
// granted or echoed ID, an ok flag and the used count after the operation.
// The bitmap lives in a RAM of MAP_WORDS = ceil(MAX_IDS/32) words of 32 bits
// with registered read data. Claim, release and query pass through read,
// modify/write and respond steps. Allocate streams one bitmap word per
// cycle through the RAM read port from the next-fit pointer, wrapping to
// first_id, until it finds a free ID or has visited every word. Clear, and
// the sweep after reset, zero the RAM one word per cycle, during which no
// request is taken; clear then goes on to respond. A new request is taken
// while the previous response still waits on rsp_ready. The user must write
// first_id through cfg_wr_en/cfg_wr_data only while idle; the block does
// not enforce this. Issue clear after changing it.
// ----------------------------------------------------------------------------
`include "bitmap_id_allocator_core_assert.svh"

module bitmap_id_allocator_core #(
    parameter int MAX_IDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  cmd,
    input  logic [9:0]  req_id,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [9:0]  result_id,
    output logic        ok,
    output logic [10:0] used_count
);

    localparam int MAP_WORDS = (MAX_IDS + 31) / 32;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = AW + bida_pkg::BIT_W;       // bit index in the map
    localparam int KW        = $clog2(MAX_IDS + 1);        // used count
    localparam int PW        = (KW > 11) ? KW : 11;        // ID arithmetic
    localparam int OW        = (KW > 11) ? KW : 11;        // count before trim

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    localparam logic [PW-1:0] MAX_P = PW'(MAX_IDS);

    // Control state
    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  clr_addr_reg, clr_addr_next;
    logic           clr_push_reg, clr_push_next;
    logic [PW-1:0]  np_reg, np_next;
    logic [KW-1:0]  count_reg, count_next;
    logic [9:0]     first_id_reg;
    logic           rsp_valid_reg, rsp_valid_next;

    // Per-transaction working registers
    bida_pkg::cmd_t     cmd_reg, cmd_next;
    logic [9:0]         id_reg, id_next;
    bida_pkg::bit_pos_t bpos_reg, bpos_next;
    logic [AW-1:0]      word_reg, word_next;
    logic               phase_reg, phase_next;
    logic [9:0]         res_id_reg, res_id_next;
    logic               res_ok_reg, res_ok_next;
    logic [9:0]         out_id_reg, out_id_next;
    logic               out_ok_reg, out_ok_next;
    logic [10:0]        out_cnt_reg, out_cnt_next;

    // RAM port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    bida_pkg::word_t    ram_wdata;
    logic [AW-1:0]      ram_raddr;
    bida_pkg::word_t    ram_rdata;

    // Search geometry, derived from first_id and the next-fit pointer
    logic [PW-1:0]      fid_p;
    logic               np_in_range;
    logic               range_empty;
    logic [PW-1:0]      scan_origin;
    logic [BW-1:0]      start_b;
    logic [BW-1:0]      last_b;
    logic [AW-1:0]      start_word;
    bida_pkg::bit_pos_t start_bit;
    logic [AW-1:0]      last_word;
    bida_pkg::bit_pos_t last_bit;

    // Request-side decode
    logic [PW-1:0]      req_p;
    logic               req_in_range;
    logic [BW-1:0]      req_b;
    logic [PW-1:0]      id_p;

    // Scan results
    logic               scan_found;
    bida_pkg::bit_pos_t scan_pos;
    logic               scan_final;
    logic [AW-1:0]      scan_word_nxt;
    logic               scan_phase_nxt;
    logic [PW-1:0]      grant_id;
    logic [PW-1:0]      grant_inc;

    logic               bit_used;
    bida_pkg::word_t    sel_mask;
    logic [OW-1:0]      count_w;

    assign fid_p       = PW'(first_id_reg);
    assign np_in_range = (np_reg >= fid_p) && (np_reg < MAX_P);
    assign range_empty = (fid_p >= MAX_P);
    assign scan_origin = np_in_range ? np_reg : fid_p;
    assign start_b     = BW'(scan_origin - fid_p);
    assign last_b      = BW'(MAX_P - fid_p - PW'(1));
    assign start_word  = start_b[BW-1:bida_pkg::BIT_W];
    assign start_bit   = start_b[bida_pkg::BIT_W-1:0];
    assign last_word   = last_b[BW-1:bida_pkg::BIT_W];
    assign last_bit    = last_b[bida_pkg::BIT_W-1:0];

    assign req_p        = PW'(req_id);
    assign req_in_range = (req_p >= fid_p) && (req_p < MAX_P);
    assign req_b        = BW'(req_p - fid_p);
    assign id_p         = PW'(id_reg);

    bida_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bida_word_scan #(
        .AW (AW)
    ) u_word_scan (
        .data       (ram_rdata),
        .word       (word_reg),
        .wrapped    (phase_reg),
        .start_word (start_word),
        .start_bit  (start_bit),
        .last_word  (last_word),
        .last_bit   (last_bit),
        .found      (scan_found),
        .pos        (scan_pos)
    );

    // Walk order: start word upward to the last word, then word 0 up to the
    // start word again for the bits below the pointer.
    always_comb
    begin
        scan_final = phase_reg && (word_reg == start_word);
        if (!phase_reg)
        begin
            if (word_reg == last_word)
            begin
                scan_word_nxt  = '0;
                scan_phase_nxt = 1'b1;
            end
            else
            begin
                scan_word_nxt  = word_reg + AW'(1);
                scan_phase_nxt = 1'b0;
            end
        end
        else if (scan_final)
        begin
            scan_word_nxt  = word_reg;
            scan_phase_nxt = 1'b1;
        end
        else
        begin
            scan_word_nxt  = word_reg + AW'(1);
            scan_phase_nxt = 1'b1;
        end
    end

    assign grant_id  = fid_p + PW'({word_reg, scan_pos});
    assign grant_inc = grant_id + PW'(1);
    assign sel_mask  = bida_pkg::word_t'(1) << bpos_reg;
    assign bit_used  = |(ram_rdata & sel_mask);
    assign count_w   = OW'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_push_next  = clr_push_reg;
        np_next        = np_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        bpos_next      = bpos_reg;
        word_next      = word_reg;
        phase_next     = phase_reg;
        res_id_next    = res_id_reg;
        res_ok_next    = res_ok_reg;
        out_id_next    = out_id_reg;
        out_ok_next    = out_ok_reg;
        out_cnt_next   = out_cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = word_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = word_reg;

        // Drop the response once the consumer takes it.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAP_WORDS - 1))
                begin
                    clr_addr_next = '0;
                    count_next    = '0;
                    np_next       = fid_p;
                    state_next    = clr_push_reg ? S_PUSH : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = cmd;
                    id_next     = req_id;
                    res_id_next = req_id;
                    res_ok_next = 1'b0;
                    bpos_next   = req_b[bida_pkg::BIT_W-1:0];
                    word_next   = req_b[BW-1:bida_pkg::BIT_W];
                    ram_raddr   = req_b[BW-1:bida_pkg::BIT_W];
                    case (cmd)
                        bida_pkg::CMD_ALLOC:
                        begin
                            res_id_next = '0;
                            word_next   = start_word;
                            phase_next  = 1'b0;
                            ram_raddr   = start_word;
                            state_next  = range_empty ? S_PUSH : S_SCAN;
                        end
                        bida_pkg::CMD_CLAIM,
                        bida_pkg::CMD_RELEASE,
                        bida_pkg::CMD_QUERY:
                        begin
                            state_next = req_in_range ? S_MOD : S_PUSH;
                        end
                        bida_pkg::CMD_CLEAR:
                        begin
                            res_ok_next   = 1'b1;
                            clr_push_next = 1'b1;
                            clr_addr_next = '0;
                            state_next    = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end

            S_MOD:
            begin
                ram_waddr  = word_reg;
                state_next = S_PUSH;
                case (cmd_reg)
                    bida_pkg::CMD_CLAIM:
                    begin
                        if (!bit_used)
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = ram_rdata | sel_mask;
                            count_next  = count_reg + KW'(1);
                            res_ok_next = 1'b1;
                        end
                    end
                    bida_pkg::CMD_RELEASE:
                    begin
                        if (bit_used)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~sel_mask;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - KW'(1);
                            end
                            if (id_p < np_reg)
                            begin
                                np_next = id_p;
                            end
                            res_ok_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_ok_next = bit_used;
                    end
                endcase
            end

            S_SCAN:
            begin
                // Issue the next word while checking the one that just arrived.
                ram_raddr  = scan_word_nxt;
                word_next  = scan_word_nxt;
                phase_next = scan_phase_nxt;
                if (scan_found)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = word_reg;
                    ram_wdata   = ram_rdata | (bida_pkg::word_t'(1) << scan_pos);
                    count_next  = count_reg + KW'(1);
                    np_next     = (grant_inc >= MAX_P) ? fid_p : grant_inc;
                    res_id_next = grant_id[9:0];
                    res_ok_next = 1'b1;
                    state_next  = S_PUSH;
                end
                else if (scan_final)
                begin
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                // Hold until the output slot is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_ok_next    = res_ok_reg;
                    out_cnt_next   = count_w[10:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            clr_push_reg  <= 1'b0;
            np_reg        <= '0;
            count_reg     <= '0;
            first_id_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_push_reg  <= clr_push_next;
            np_reg        <= np_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                first_id_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        bpos_reg    <= bpos_next;
        word_reg    <= word_next;
        phase_reg   <= phase_next;
        res_id_reg  <= res_id_next;
        res_ok_reg  <= res_ok_next;
        out_id_reg  <= out_id_next;
        out_ok_reg  <= out_ok_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign result_id  = out_id_reg;
    assign ok         = out_ok_reg;
    assign used_count = out_cnt_reg;

    `BIDA_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= KW'(MAX_IDS), "used count above MAX_IDS")
    `BIDA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")
    `BIDA_ASSERT_NEXT(a_rsp_from_push, clk, rst_n, !rsp_valid_reg && state_reg != S_PUSH, !rsp_valid_reg, "response raised outside push")
    `BIDA_ASSERT_IMPL(a_ram_addr, clk, rst_n, ram_we, ram_waddr <= AW'(MAP_WORDS - 1), "bitmap write beyond map")
    `BIDA_ASSERT_IMPL(a_scan_sets_bit, clk, rst_n, ram_we && state_reg == S_SCAN, ram_wdata != ram_rdata, "allocate wrote without setting a bit")

endmodule
